### src/dsfc_pkg.sv
// Shared constants, types and the damped-sine kernel table for the FIR convolver.
`default_nettype none

package dsfc_pkg;

  // Field widths and filter size.
  localparam int TAPS         = 200;
  localparam int SAMPLE_WIDTH = 16;
  localparam int COEF_WIDTH   = 16;
  localparam int SAMPLE_IN_W  = 16;
  localparam int OUT_W        = 40;

  // Derived widths.
  localparam int IDX_W  = $clog2(TAPS);
  localparam int CNT_W  = $clog2(TAPS + 1);
  localparam int PROD_W = SAMPLE_WIDTH + COEF_WIDTH;
  localparam int ACC_W  = OUT_W;

  // Fixed-point precision used while the kernel table is built.
  localparam int    FRAC = 60;
  localparam longint QONE = 64'sd1 <<< FRAC;

  typedef logic signed [SAMPLE_WIDTH-1:0] smp_t;
  typedef logic signed [COEF_WIDTH-1:0]   coef_t;
  typedef logic signed [PROD_W-1:0]       prod_t;
  typedef logic signed [ACC_W-1:0]        acc_t;
  typedef coef_t                          coef_rom_t [TAPS];

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;    // request accepted: store sample, restart the sum
    logic issue;   // start one multiply-accumulate step
    logic finish;  // move the finished sum into the output register
  } dsfc_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic last_issue;  // the current step is the last one of this request
    logic pipe_busy;   // steps are still in flight in the MAC pipeline
    logic out_free;    // the output register can take a new result
  } dsfc_sts_t;

  // Product of two Q60 values, rounded to nearest with ties away from zero.
  function automatic longint qmul(longint a, longint b);
    logic         neg;
    logic [63:0]  ua;
    logic [63:0]  ub;
    logic [127:0] p;
    logic [63:0]  m;
    neg = (a < 0) != (b < 0);
    ua  = (a < 0) ? -a : a;
    ub  = (b < 0) ? -b : b;
    p   = {64'd0, ua} * {64'd0, ub};
    m   = p[FRAC+63:FRAC] + {63'd0, p[FRAC-1]};
    return neg ? -longint'(m) : longint'(m);
  endfunction

  // Q60 value to a coefficient, rounded to nearest and saturated.
  function automatic coef_t quantize(longint v);
    int unsigned sh;
    longint      lim;
    logic [63:0] mag;
    longint      r;
    sh  = FRAC - (COEF_WIDTH - 1);
    lim = 64'sd1 <<< (COEF_WIDTH - 1);
    mag = (v < 0) ? -v : v;
    mag = (mag + (64'd1 << (sh - 1))) >> sh;
    r   = (v < 0) ? -longint'(mag) : longint'(mag);
    if (r > lim - 1) r = lim - 1;
    if (r < -lim) r = -lim;
    return coef_t'(r);
  endfunction

  // Phase step of 0.1256 rad per tap and its square, in Q60.
  localparam longint QONE_QUOT = QONE / 1250;
  localparam longint QONE_REM  = QONE % 1250;
  localparam longint THETA     = 157 * QONE_QUOT + (157 * QONE_REM + 625) / 1250;
  localparam longint THETA_SQ  = qmul(THETA, THETA);

  // Taylor terms of sin(theta).
  localparam longint SIN_T1  = -qmul(THETA,   THETA_SQ) / 6;
  localparam longint SIN_T2  = -qmul(SIN_T1,  THETA_SQ) / 20;
  localparam longint SIN_T3  = -qmul(SIN_T2,  THETA_SQ) / 42;
  localparam longint SIN_T4  = -qmul(SIN_T3,  THETA_SQ) / 72;
  localparam longint SIN_T5  = -qmul(SIN_T4,  THETA_SQ) / 110;
  localparam longint SIN_T6  = -qmul(SIN_T5,  THETA_SQ) / 156;
  localparam longint SIN_T7  = -qmul(SIN_T6,  THETA_SQ) / 210;
  localparam longint SIN_T8  = -qmul(SIN_T7,  THETA_SQ) / 272;
  localparam longint SIN_T9  = -qmul(SIN_T8,  THETA_SQ) / 342;
  localparam longint SIN_T10 = -qmul(SIN_T9,  THETA_SQ) / 420;

  // Taylor terms of cos(theta).
  localparam longint COS_T1  = -qmul(QONE,    THETA_SQ) / 2;
  localparam longint COS_T2  = -qmul(COS_T1,  THETA_SQ) / 12;
  localparam longint COS_T3  = -qmul(COS_T2,  THETA_SQ) / 30;
  localparam longint COS_T4  = -qmul(COS_T3,  THETA_SQ) / 56;
  localparam longint COS_T5  = -qmul(COS_T4,  THETA_SQ) / 90;
  localparam longint COS_T6  = -qmul(COS_T5,  THETA_SQ) / 132;
  localparam longint COS_T7  = -qmul(COS_T6,  THETA_SQ) / 182;
  localparam longint COS_T8  = -qmul(COS_T7,  THETA_SQ) / 240;
  localparam longint COS_T9  = -qmul(COS_T8,  THETA_SQ) / 306;
  localparam longint COS_T10 = -qmul(COS_T9,  THETA_SQ) / 380;

  // Taylor terms of exp(-0.05), the damping per tap.
  localparam longint DAMP    = -((QONE + 10) / 20);
  localparam longint EXP_T1  = qmul(QONE,    DAMP);
  localparam longint EXP_T2  = qmul(EXP_T1,  DAMP) / 2;
  localparam longint EXP_T3  = qmul(EXP_T2,  DAMP) / 3;
  localparam longint EXP_T4  = qmul(EXP_T3,  DAMP) / 4;
  localparam longint EXP_T5  = qmul(EXP_T4,  DAMP) / 5;
  localparam longint EXP_T6  = qmul(EXP_T5,  DAMP) / 6;
  localparam longint EXP_T7  = qmul(EXP_T6,  DAMP) / 7;
  localparam longint EXP_T8  = qmul(EXP_T7,  DAMP) / 8;
  localparam longint EXP_T9  = qmul(EXP_T8,  DAMP) / 9;
  localparam longint EXP_T10 = qmul(EXP_T9,  DAMP) / 10;
  localparam longint EXP_T11 = qmul(EXP_T10, DAMP) / 11;
  localparam longint EXP_T12 = qmul(EXP_T11, DAMP) / 12;
  localparam longint EXP_T13 = qmul(EXP_T12, DAMP) / 13;
  localparam longint EXP_T14 = qmul(EXP_T13, DAMP) / 14;
  localparam longint EXP_T15 = qmul(EXP_T14, DAMP) / 15;
  localparam longint EXP_T16 = qmul(EXP_T15, DAMP) / 16;

  localparam longint SIN_STEP = THETA + SIN_T1 + SIN_T2 + SIN_T3 + SIN_T4 + SIN_T5
                              + SIN_T6 + SIN_T7 + SIN_T8 + SIN_T9 + SIN_T10;
  localparam longint COS_STEP = QONE + COS_T1 + COS_T2 + COS_T3 + COS_T4 + COS_T5
                              + COS_T6 + COS_T7 + COS_T8 + COS_T9 + COS_T10;
  localparam longint DECAY_STEP = QONE + EXP_T1 + EXP_T2 + EXP_T3 + EXP_T4 + EXP_T5
                                + EXP_T6 + EXP_T7 + EXP_T8 + EXP_T9 + EXP_T10
                                + EXP_T11 + EXP_T12 + EXP_T13 + EXP_T14 + EXP_T15
                                + EXP_T16;

  // Complex factor that advances the kernel by one tap.
  localparam longint ROT_RE = qmul(DECAY_STEP, COS_STEP);
  localparam longint ROT_IM = qmul(DECAY_STEP, SIN_STEP);

  // Kernel h[k] = sin(0.1256 k) * exp(-0.05 k), built by a complex rotation per tap.
  function automatic coef_rom_t build_kernel();
    coef_rom_t rom;
    longint    re, im, nr, ni;
    re = QONE;
    im = 0;
    for (int n = 0; n < TAPS; n++) begin
      rom[n] = quantize(im);
      nr = qmul(re, ROT_RE) - qmul(im, ROT_IM);
      ni = qmul(re, ROT_IM) + qmul(im, ROT_RE);
      re = nr;
      im = ni;
    end
    return rom;
  endfunction

  localparam coef_rom_t KERNEL_ROM = build_kernel();

endpackage

`default_nettype wire

### src/dsfc_sample_if.sv
// Handshake channel carrying one input sample request.
`default_nettype none

interface dsfc_sample_if
  import dsfc_pkg::*;
();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_IN_W-1:0] sample;
  logic                          start_req;

  modport source (output valid, output sample, output start_req, input ready);
  modport sink (input valid, input sample, input start_req, output ready);
endinterface

`default_nettype wire

### src/dsfc_result_if.sv
// Handshake channel carrying one convolution result request.
`default_nettype none

interface dsfc_result_if
  import dsfc_pkg::*;
();
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] filtered;

  modport source (output valid, output filtered, input ready);
  modport sink (input valid, input filtered, output ready);
endinterface

`default_nettype wire

### src/dsfc_ctrl.sv
// Controller state machine sequencing accept, MAC steps, drain and result hand-off.
`default_nettype none

module dsfc_ctrl
  import dsfc_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire dsfc_sts_t sts,
  output dsfc_cmd_t      cmd
);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_RUN   = 3'b010,
    ST_DRAIN = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  // Next state and commands.
  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        cmd.issue = 1'b1;
        if (sts.last_issue) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (!sts.pipe_busy && sts.out_free) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

### src/dsfc_datapath.sv
// Datapath: sample history memory, kernel table, pipelined MAC and output register.
`default_nettype none

module dsfc_datapath
  import dsfc_pkg::*;
(
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire dsfc_cmd_t                     cmd,
  output dsfc_sts_t                          sts,
  input  wire logic signed [SAMPLE_IN_W-1:0] sample,
  input  wire logic                          start_req,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic signed [OUT_W-1:0]            filtered
);

  smp_t             mem [TAPS];
  logic [IDX_W-1:0] ws;
  logic [CNT_W-1:0] vc;
  logic [IDX_W-1:0] rd_idx;
  logic [CNT_W-1:0] k;
  smp_t             data_q;
  coef_t            coef_q;
  logic             v1;
  prod_t            prod;
  logic             v2;
  acc_t             acc;

  // Status toward the controller.
  always_comb begin
    sts.last_issue = (k + CNT_W'(1)) == vc;
    sts.pipe_busy  = v1 | v2;
    sts.out_free   = !out_valid || out_ready;
  end

  // History memory: the new sample is written when the request is accepted.
  always_ff @(posedge clk) begin
    if (cmd.load) mem[ws] <= sample[SAMPLE_WIDTH-1:0];
    if (cmd.issue) begin
      data_q <= mem[rd_idx];
      coef_q <= KERNEL_ROM[k[IDX_W-1:0]];
    end
  end

  // Ring position and count of samples in the current record.
  always_ff @(posedge clk) begin
    if (rst) begin
      ws <= '0;
      vc <= '0;
    end else if (cmd.load) begin
      ws <= (ws == IDX_W'(TAPS - 1)) ? '0 : ws + IDX_W'(1);
      if (start_req) begin
        vc <= CNT_W'(1);
      end else if (vc < CNT_W'(TAPS)) begin
        vc <= vc + CNT_W'(1);
      end
    end
  end

  // Step counters: tap index goes up, history index walks back through the ring.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rd_idx <= ws;
      k      <= '0;
    end else if (cmd.issue) begin
      rd_idx <= (rd_idx == '0) ? IDX_W'(TAPS - 1) : rd_idx - IDX_W'(1);
      k      <= k + CNT_W'(1);
    end
  end

  // Multiply stage.
  always_ff @(posedge clk) begin
    prod <= data_q * coef_q;
  end

  // Pipeline valid flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= cmd.issue;
      v2 <= v1;
    end
  end

  // Accumulator, exact and wrapping at the output width.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      acc <= '0;
    end else if (v2) begin
      acc <= acc + {{(ACC_W - PROD_W){prod[PROD_W-1]}}, prod};
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) filtered <= acc;
  end

endmodule

`default_nettype wire

### src/damped_sine_fir_convolver.sv
// Top level of the damped-sine FIR convolver.
// Each accepted sample request produces one result: the full convolution of the
// samples since the last start_req (or since reset) with a fixed 200-tap
// damped-sine kernel in Q1.15, summed exactly in 40 bits with 15 fraction bits.
// Each request is worked through one tap per cycle over N taps, where N (1 to 200)
// is the number of samples counted in the current record, by the single
// multiply-accumulate unit and the one read port of the sample history memory; the
// next request waits until this result is in the output register. A new sample is
// accepted while a finished result still waits in the output register.
// Feed 199 zero samples after a record to obtain its tail.
`default_nettype none

module damped_sine_fir_convolver
  import dsfc_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  dsfc_sample_if.sink   samples,
  dsfc_result_if.source results
);

  dsfc_cmd_t cmd;
  dsfc_sts_t sts;

  dsfc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (samples.valid),
    .in_ready (samples.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  dsfc_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .sample    (samples.sample),
    .start_req (samples.start_req),
    .out_valid (results.valid),
    .out_ready (results.ready),
    .filtered  (results.filtered)
  );

  // An accepted request keeps the input closed for the following cycle.
  assert property (@(posedge clk) disable iff (rst)
    samples.valid && samples.ready |=> !samples.ready)
    else $error("input accepted again right after a request");

  // A result is only written once the MAC pipeline has drained and the output register is free.
  assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> !sts.pipe_busy && sts.out_free)
    else $error("result written while MAC pipeline busy or output full");

  // Issuing stops right after the last step of a request.
  assert property (@(posedge clk) disable iff (rst)
    cmd.issue && sts.last_issue |=> !cmd.issue && !cmd.load)
    else $error("MAC steps continued past the last tap");

endmodule

`default_nettype wire

### tb/damped_sine_fir_convolver_tb.sv
// Self-checking testbench for the damped-sine FIR convolver.
`timescale 1ns / 100ps

module damped_sine_fir_convolver_tb
  import dsfc_pkg::*;
();

  localparam smp_t SMP_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam smp_t SMP_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

  logic clk = 1'b0;
  logic rst = 1'b1;

  dsfc_sample_if samples ();
  dsfc_result_if results ();

  damped_sine_fir_convolver uut (
    .clk     (clk),
    .rst     (rst),
    .samples (samples),
    .results (results)
  );

  // Own copy of the filter: quantized kernel, sample ring and record bookkeeping.
  coef_t kernel_q15 [TAPS];
  smp_t  hist_ring [TAPS];
  int    counted   = 0;
  int    next_slot = 0;

  // Filter outputs predicted for accepted requests, oldest first.
  acc_t  filtered_due [$];

  int    mismatch_count = 0;
  int    items_sent     = 0;
  int    idle_pct       = 0;
  int    stall_pct      = 0;
  logic  holding        = 1'b0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Kernel h[k] = sin(0.1256 k) * exp(-0.05 k) in Q1.15, rounded half away from zero.
  initial begin : kernel_table
    real h;
    real scaled;
    longint q;
    for (int k = 0; k < TAPS; k++) begin
      h      = $sin(0.1256 * k) * $exp(-0.05 * k);
      scaled = h * (2.0 ** (COEF_WIDTH - 1));
      if (scaled >= 0.0) q = $rtoi(scaled + 0.5);
      else q = -$rtoi(-scaled + 0.5);
      if (q > (64'sd1 <<< (COEF_WIDTH - 1)) - 1) q = (64'sd1 <<< (COEF_WIDTH - 1)) - 1;
      if (q < -(64'sd1 <<< (COEF_WIDTH - 1))) q = -(64'sd1 <<< (COEF_WIDTH - 1));
      kernel_q15[k] = coef_t'(q);
      hist_ring[k]  = '0;
    end
  end

  // Convolution of the current record with the kernel; updates the ring state.
  function automatic acc_t convolve_sample(logic [SAMPLE_IN_W-1:0] raw, logic first);
    longint sum;
    int     idx;
    sum = 0;
    if (first) counted = 0;
    hist_ring[next_slot] = smp_t'(raw[SAMPLE_WIDTH-1:0]);
    if (counted < TAPS) counted++;
    for (int k = 0; k < counted; k++) begin
      idx = (next_slot >= k) ? next_slot - k : next_slot + TAPS - k;
      sum += longint'(kernel_q15[k]) * longint'(hist_ring[idx]);
    end
    next_slot = (next_slot + 1 >= TAPS) ? 0 : next_slot + 1;
    return acc_t'(sum);
  endfunction

  // Mostly full-range samples, with extremes and small values mixed in.
  function automatic logic [SAMPLE_IN_W-1:0] random_sample();
    int pick;
    pick = $urandom_range(9);
    case (pick)
      0: return SMP_MAX;
      1: return SMP_MIN;
      2: return SAMPLE_IN_W'($urandom_range(0, 32) - 16);
      default: return SAMPLE_IN_W'($urandom);
    endcase
  endfunction

  task automatic report_mismatch(string what, acc_t want, acc_t got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("%0t ns: %s: filtered expected %0d, got %0d", $time, what, want, got);
  endtask

  // Offers one sample request, waits for its acceptance and records the prediction.
  // Valid stays high after acceptance so back-to-back requests need no extra edge.
  task automatic send_sample(input logic [SAMPLE_IN_W-1:0] value, input logic first);
    int gap;
    gap = 0;
    while ($urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      samples.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    samples.valid     <= 1'b1;
    samples.sample    <= value;
    samples.start_req <= first;
    @(posedge clk);
    while (!samples.ready) @(posedge clk);
    filtered_due.push_back(convolve_sample(value, first));
    items_sent++;
  endtask

  // Receiver: random stalls, or a full hold-off while holding is set.
  initial begin
    results.ready = 1'b0;
    forever begin
      @(posedge clk);
      results.ready <= !holding && ($urandom_range(99) >= stall_pct);
    end
  end

  // Holds the result channel off for a fixed number of cycles.
  task automatic hold_result_channel(int cycles);
    holding <= 1'b1;
    repeat (cycles) @(posedge clk);
    holding <= 1'b0;
  endtask

  // Compares every accepted result with the oldest prediction.
  always @(posedge clk) begin : check_results
    acc_t want;
    if (!rst && results.valid && results.ready) begin
      if (filtered_due.size() == 0) begin
        report_mismatch("result with no request pending", '0, results.filtered);
      end else begin
        want = filtered_due.pop_front();
        if (results.filtered !== want)
          report_mismatch("wrong result", want, results.filtered);
      end
    end
  end

  // Samples right after reset form a record even without a start flag.
  task automatic test_record_without_start();
    send_sample(SMP_MAX, 1'b0);
    send_sample(SMP_MAX, 1'b0);
    send_sample(SMP_MIN, 1'b0);
  endtask

  // Extreme values of the sample, accumulated over a short record.
  task automatic test_extreme_samples();
    send_sample(SMP_MIN, 1'b1);
    repeat (3) send_sample(SMP_MIN, 1'b0);
    send_sample(SMP_MAX, 1'b0);
    send_sample('0, 1'b0);
  endtask

  // A unit impulse followed by zeros walks through the first kernel taps.
  task automatic test_impulse_response();
    send_sample(SAMPLE_IN_W'(1), 1'b1);
    repeat (5) send_sample('0, 1'b0);
  endtask

  // Start flags on consecutive requests and alternating bit patterns.
  task automatic test_start_flag_pairs();
    send_sample(SAMPLE_IN_W'(100), 1'b1);
    send_sample(SAMPLE_IN_W'(-100), 1'b1);
    send_sample(16'h5555, 1'b1);
    send_sample(16'haaaa, 1'b0);
    send_sample('1, 1'b0);
  endtask

  // Random records: mostly short, some medium, a few past the full kernel length
  // with an optional zero tail. Stray start flags and unflagged records add noise.
  task automatic test_random_records(int idle, int stall, int item_goal);
    int   goal_end;
    int   len;
    int   roll;
    logic first;
    idle_pct  = idle;
    stall_pct <= stall;
    goal_end  = items_sent + item_goal;
    while (items_sent < goal_end) begin
      roll = $urandom_range(99);
      if (roll < 85) len = $urandom_range(1, 24);
      else if (roll < 96) len = $urandom_range(25, 120);
      else len = $urandom_range(TAPS, TAPS + 60);
      first = ($urandom_range(9) != 0);
      for (int i = 0; i < len; i++)
        send_sample(random_sample(), (i == 0) ? first : ($urandom_range(49) == 0));
      if (len >= TAPS && $urandom_range(1) == 1)
        repeat (TAPS - 1) send_sample('0, 1'b0);
    end
  endtask

  // The receiver holds off for a long stretch while requests keep coming,
  // so the output register fills and the block stalls its input.
  task automatic test_backpressure();
    idle_pct  = 0;
    stall_pct <= 0;
    fork
      hold_result_channel(1500);
    join_none
    for (int i = 0; i < 40; i++)
      send_sample(random_sample(), (i % 5) == 0);
  endtask

  initial begin
    samples.valid     <= 1'b0;
    samples.sample    <= '0;
    samples.start_req <= 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    test_record_without_start();
    test_extreme_samples();
    test_impulse_response();
    test_start_flag_pairs();
    test_random_records(0, 0, 470);
    test_random_records(72, 0, 470);
    test_random_records(0, 72, 470);
    test_random_records(17, 17, 470);
    test_backpressure();
    samples.valid <= 1'b0;

    // Let the pipeline drain, then look for requests that never produced a result.
    for (int w = 0; w < 20000 && filtered_due.size() != 0; w++) @(posedge clk);
    repeat (300) @(posedge clk);
    while (filtered_due.size() != 0)
      report_mismatch("result never arrived", filtered_due.pop_front(), '0);

    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog well beyond the slowest legal run.
  initial begin
    #10_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule

### files.f
src/dsfc_pkg.sv
src/dsfc_sample_if.sv
src/dsfc_result_if.sv
src/dsfc_ctrl.sv
src/dsfc_datapath.sv
src/damped_sine_fir_convolver.sv
tb/damped_sine_fir_convolver_tb.sv
